### rtl/price_level_order_book_assert.svh
// Assertion macros for the price-level order book.
`ifndef PRICE_LEVEL_ORDER_BOOK_ASSERT_SVH
`define PRICE_LEVEL_ORDER_BOOK_ASSERT_SVH
`ifndef SYNTH
`define PLOB_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define PLOB_ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define PLOB_ASSERT_IMP(label, clk, rst_n, a, c)
`define PLOB_ASSERT_NEXT(label, clk, rst_n, a, c)
`endif
`endif

### rtl/plob_pkg.sv
// Package with shared types and codes of the price-level order book.
`timescale 1ns / 1ps
package plob_pkg;
    typedef enum logic [1:0] {
        ACT_ADD    = 2'd0,
        ACT_CANCEL = 2'd1,
        ACT_MODIFY = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_INVALID  = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]  action;
        logic [63:0] ord_key;
        logic        side;
        logic [31:0] price_ticks;
        logic [31:0] quantity;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic        bid_valid;
        logic [31:0] bid_price;
        logic [31:0] bid_size;
        logic        ask_valid;
        logic [31:0] ask_price;
        logic [31:0] ask_size;
    } t_rsp;
endpackage

### rtl/plob_if.sv
// Valid/ready channel interfaces for requests and results.
`timescale 1ns / 1ps
interface plob_req_if;
    import plob_pkg::*;
    logic valid;
    logic ready;
    t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface plob_rsp_if;
    import plob_pkg::*;
    logic valid;
    logic ready;
    t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### rtl/price_level_order_book.sv
// Top level of the price-level order book: sequencer, tables and best-price scan.
// An action is taken while i_req.ready is high and gives one result. The block
// walks its tables with one RAM port per table, one entry a cycle: an order
// search, then a level search, then a best-price rescan of the touched side. The
// next action is taken only once the result has been loaded; invalid adds and
// unused actions skip the searches. Valid bits sit in flip-flops and reset clears
// them at once, so no clearing pass is needed.
// The result register frees the sequencer for the next action while a result waits.
`timescale 1ns / 1ps
`include "price_level_order_book_assert.svh"
module price_level_order_book #(
    parameter int MAX_ORDERS = 256,
    parameter int MAX_LEVELS = 128,
    parameter int PRICE_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    plob_req_if.sink       i_req,
    plob_rsp_if.source     o_rsp
);
    import plob_pkg::*;

    localparam int OW = $clog2(MAX_ORDERS);
    localparam int LW = $clog2(MAX_LEVELS);
    localparam int PB = (PRICE_BITS < 32) ? PRICE_BITS : 32;

    typedef enum logic [3:0] {
        S_IDLE, S_OSCAN, S_OREC, S_LSCAN, S_UPD, S_UPD2,
        S_BSCAN, S_BEST, S_DONE
    } t_state;

    // Order record: side, price, quantity. Level record: quantity, count.
    localparam int ORW = 1 + PB + 32;
    localparam int LPW = 1 + PB;

    t_state r_state;
    logic [1:0] r_act;
    logic [63:0] r_key;
    logic r_side;
    logic [PB-1:0] r_price;
    logic [31:0] r_qty, r_oldq;
    logic [1:0] r_status;
    logic [OW:0] r_oi;
    logic [LW:0] r_li;
    logic r_ofound, r_ofree_ok, r_lfound, r_lfree_ok, r_bfound, r_rd;
    logic [OW-1:0] r_ohit, r_ofree;
    logic [LW-1:0] r_lhit, r_lfree;
    logic [MAX_ORDERS-1:0] r_ovalid;
    logic [MAX_LEVELS-1:0] r_lvalid;
    logic [PB-1:0] r_bp, r_best_bid_p, r_best_ask_p;
    logic [31:0] r_bq, r_best_bid_q, r_best_ask_q;
    logic r_out_valid;
    t_rsp r_out;

    // RAM ports
    logic ok_we, or_we, lp_we, lr_we;
    logic [OW-1:0] o_addr;
    logic [LW-1:0] l_addr;
    logic [63:0] ok_rd;
    logic [ORW-1:0] or_rd, or_wd;
    logic [LPW-1:0] lp_rd, lp_wd;
    logic [63:0] lr_rd, lr_wd;

    plob_ram #(.WIDTH(64), .DEPTH(MAX_ORDERS)) u_okey (
        .i_clk(i_clk), .i_we(ok_we), .i_addr(o_addr), .i_wdata(r_key), .o_rdata(ok_rd));
    plob_ram #(.WIDTH(ORW), .DEPTH(MAX_ORDERS)) u_orec (
        .i_clk(i_clk), .i_we(or_we), .i_addr(o_addr), .i_wdata(or_wd), .o_rdata(or_rd));
    plob_ram #(.WIDTH(LPW), .DEPTH(MAX_LEVELS)) u_lps (
        .i_clk(i_clk), .i_we(lp_we), .i_addr(l_addr), .i_wdata(lp_wd), .o_rdata(lp_rd));
    plob_ram #(.WIDTH(64), .DEPTH(MAX_LEVELS)) u_lrec (
        .i_clk(i_clk), .i_we(lr_we), .i_addr(l_addr), .i_wdata(lr_wd), .o_rdata(lr_rd));

    // Entry that was read in the previous cycle.
    logic [OW-1:0] oi_prev;
    logic [LW-1:0] li_prev;
    assign oi_prev = r_oi[OW-1:0] - 1'b1;
    assign li_prev = r_li[LW-1:0] - 1'b1;

    logic new_level, is_cancel;
    logic [31:0] lq_new, lc_new;
    assign new_level = (r_act == ACT_ADD) && !r_lfound;
    assign is_cancel = (r_act == ACT_CANCEL) || (r_act == ACT_MODIFY && r_qty == '0);

    // The comparator of the best-price scan.
    logic cmp_better;
    assign cmp_better = r_side ? (lp_rd[PB-1:0] < r_bp) : (lp_rd[PB-1:0] > r_bp);

    always_comb begin
        ok_we = 1'b0;
        or_we = 1'b0;
        lp_we = 1'b0;
        lr_we = 1'b0;
        o_addr = r_oi[OW-1:0];
        l_addr = r_li[LW-1:0];
        or_wd = {r_side, r_price, r_qty};
        lp_wd = {r_side, r_price};
        lq_new = lr_rd[63:32];
        lc_new = lr_rd[31:0];
        if (r_act == ACT_ADD) begin
            lq_new = (new_level ? 32'd0 : lr_rd[63:32]) + r_qty;
            lc_new = (new_level ? 32'd0 : lr_rd[31:0]) + 32'd1;
        end else if (is_cancel) begin
            lq_new = lr_rd[63:32] - r_oldq;
            lc_new = lr_rd[31:0] - 32'd1;
        end else begin
            lq_new = lr_rd[63:32] - r_oldq + r_qty;
        end
        lr_wd = {lq_new, lc_new};
        case (r_state)
            S_OREC: o_addr = r_ohit;
            S_UPD: begin
                l_addr = new_level ? r_lfree : r_lhit;
            end
            S_UPD2: begin
                o_addr = r_ohit;
                l_addr = new_level ? r_lfree : r_lhit;
                lp_we = new_level;
                lr_we = r_lfound || new_level;
                if (r_act == ACT_ADD) begin
                    ok_we = 1'b1;
                    or_we = 1'b1;
                end else if (r_act == ACT_MODIFY && !is_cancel) begin
                    or_we = 1'b1;
                    or_wd = {r_side, r_price, r_qty};
                end
            end
            default: ;
        endcase
    end

    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovalid <= '0;
            r_lvalid <= '0;
            r_best_bid_p <= '0;
            r_best_bid_q <= '0;
            r_best_ask_p <= '0;
            r_best_ask_q <= '0;
            r_out_valid <= 1'b0;
            r_rd <= 1'b0;
        end else begin
            // A new result is loaded when the register is empty or being drained.
            if (r_state == S_DONE && (!r_out_valid || o_rsp.ready)) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_act <= i_req.data.action;
                        r_key <= i_req.data.ord_key;
                        r_side <= i_req.data.side;
                        r_price <= i_req.data.price_ticks[PB-1:0];
                        r_qty <= i_req.data.quantity;
                        r_oi <= '0;
                        r_rd <= 1'b0;
                        r_ofound <= 1'b0;
                        r_ofree_ok <= 1'b0;
                        if (i_req.data.action == ACT_NONE) begin
                            r_status <= ST_DONE;
                            r_state <= S_DONE;
                        end else if (i_req.data.action == ACT_ADD &&
                                     (i_req.data.quantity == '0 ||
                                      i_req.data.price_ticks[PB-1:0] == '0)) begin
                            r_status <= ST_INVALID;
                            r_state <= S_DONE;
                        end else begin
                            r_status <= ST_DONE;
                            r_state <= S_OSCAN;
                        end
                    end
                end
                // One key compare per cycle against the entry read last cycle.
                S_OSCAN: begin
                    if (r_rd && !r_ofound) begin
                        if (r_ovalid[oi_prev] && ok_rd == r_key) begin
                            r_ofound <= 1'b1;
                            r_ohit <= oi_prev;
                        end else if (!r_ovalid[oi_prev] && !r_ofree_ok) begin
                            r_ofree_ok <= 1'b1;
                            r_ofree <= oi_prev;
                        end
                    end
                    r_oi <= r_oi + 1'b1;
                    if (r_oi == (OW+1)'(MAX_ORDERS)) begin
                        r_rd <= 1'b0;
                        r_state <= S_OREC;
                    end else begin
                        r_rd <= 1'b1;
                    end
                end
                S_OREC: begin
                    // The hit entry is read this cycle; the level search starts next.
                    r_li <= '0;
                    r_lfound <= 1'b0;
                    r_lfree_ok <= 1'b0;
                    if (r_act == ACT_ADD) begin
                        if (!r_ofound) begin
                            r_ohit <= r_ofree;
                        end
                        if (!r_ofound && !r_ofree_ok) begin
                            r_status <= ST_FULL;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_LSCAN;
                        end
                    end else if (!r_ofound) begin
                        r_status <= ST_NOT_FOUND;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_LSCAN;
                    end
                end
                S_LSCAN: begin
                    if (!r_rd && r_act != ACT_ADD) begin
                        // The stored record arrives now: take its side, price and quantity.
                        r_side <= or_rd[ORW-1];
                        r_price <= or_rd[ORW-2 -: PB];
                        r_oldq <= or_rd[31:0];
                    end
                    if (r_rd && !r_lfound) begin
                        if (r_lvalid[li_prev] && lp_rd == {r_side, r_price}) begin
                            r_lfound <= 1'b1;
                            r_lhit <= li_prev;
                        end else if (!r_lvalid[li_prev] && !r_lfree_ok) begin
                            r_lfree_ok <= 1'b1;
                            r_lfree <= li_prev;
                        end
                    end
                    r_li <= r_li + 1'b1;
                    if (r_li == (LW+1)'(MAX_LEVELS)) begin
                        r_rd <= 1'b0;
                        r_state <= S_UPD;
                    end else begin
                        r_rd <= 1'b1;
                    end
                end
                S_UPD: begin
                    if (r_act == ACT_ADD && !r_lfound && !r_lfree_ok) begin
                        r_status <= ST_FULL;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_UPD2;
                    end
                end
                S_UPD2: begin
                    if (r_act == ACT_ADD) begin
                        r_ovalid[r_ohit] <= 1'b1;
                        if (new_level) begin
                            r_lvalid[r_lfree] <= 1'b1;
                        end
                    end else if (is_cancel) begin
                        r_ovalid[r_ohit] <= 1'b0;
                        if (r_lfound && lc_new == '0) begin
                            r_lvalid[r_lhit] <= 1'b0;
                        end
                    end
                    r_li <= '0;
                    r_rd <= 1'b0;
                    r_bfound <= 1'b0;
                    r_bp <= '0;
                    r_bq <= '0;
                    r_state <= S_BSCAN;
                end
                // Best-price rescan of the touched side, one level a cycle.
                S_BSCAN: begin
                    if (r_rd && r_lvalid[li_prev] && lp_rd[LPW-1] == r_side &&
                        (!r_bfound || cmp_better)) begin
                        r_bfound <= 1'b1;
                        r_bp <= lp_rd[PB-1:0];
                        r_bq <= lr_rd[63:32];
                    end
                    r_li <= r_li + 1'b1;
                    if (r_li == (LW+1)'(MAX_LEVELS)) begin
                        r_rd <= 1'b0;
                        r_state <= S_BEST;
                    end else begin
                        r_rd <= 1'b1;
                    end
                end
                // The last level has been compared; the best of the side is final.
                S_BEST: begin
                    if (r_side) begin
                        r_best_ask_p <= r_bp;
                        r_best_ask_q <= r_bq;
                    end else begin
                        r_best_bid_p <= r_bp;
                        r_best_bid_q <= r_bq;
                    end
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (!r_out_valid || o_rsp.ready) begin
                        r_out.status <= r_status;
                        r_out.bid_valid <= (r_best_bid_p != '0);
                        r_out.bid_price <= 32'(r_best_bid_p);
                        r_out.bid_size <= r_best_bid_q;
                        r_out.ask_valid <= (r_best_ask_p != '0);
                        r_out.ask_price <= 32'(r_best_ask_p);
                        r_out.ask_size <= r_best_ask_q;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `PLOB_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, i_req.ready, r_state == S_IDLE)
    `PLOB_ASSERT_NEXT(a_done_out, i_clk, i_rst_n, r_state == S_DONE && !r_out_valid, r_out_valid)
    `PLOB_ASSERT_IMP(a_bid_size, i_clk, i_rst_n, r_best_bid_p == '0, r_best_bid_q == '0)
endmodule

### rtl/plob_ram.sv
// Generic single-port RAM with registered read.
`timescale 1ns / 1ps
module plob_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule
